[hw/rtl/ptae_pkg.sv]
package ptae_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int PeerW = 31;
  localparam int PrioW = 8;
  localparam int TimeW = 12;

  localparam logic [2:0] OP_MERGE = 3'd0;
  localparam logic [2:0] OP_STATUS = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_PURGE = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;
  localparam logic [2:0] OP_ELECT = 3'd5;

  localparam logic [1:0] RC_OK = 2'd0;
  localparam logic [1:0] RC_NOT_FOUND = 2'd1;
  localparam logic [1:0] RC_FULL = 2'd2;
  localparam logic [1:0] RC_BAD_INDEX = 2'd3;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_OWN_ID = 2'd1;
  localparam logic [1:0] REG_OWN_PRIO = 2'd2;

  typedef struct packed {
    logic [PeerW-1:0] peer_id;
    logic [PrioW-1:0] priority_val;
    logic [TimeW-1:0] seen_time;
    logic live;
  } entry_t;

  // Signed age now - stamp compared against the timeout; 14-bit signed math.
  function automatic logic age_above(input logic [TimeW-1:0] now_v,
                                     input logic [TimeW-1:0] stamp,
                                     input logic [TimeW-1:0] limit);
    logic signed [TimeW+1:0] age;
    age = $signed({2'b00, now_v}) - $signed({2'b00, stamp});
    return age > $signed({2'b00, limit});
  endfunction

  function automatic logic age_below(input logic [TimeW-1:0] now_v,
                                     input logic [TimeW-1:0] stamp,
                                     input logic [TimeW-1:0] limit);
    logic signed [TimeW+1:0] age;
    age = $signed({2'b00, now_v}) - $signed({2'b00, stamp});
    return age < $signed({2'b00, limit});
  endfunction

endpackage

[hw/rtl/ptae_store.sv]
module ptae_store
  import ptae_pkg::*;
(
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  entry_t          wr_data,
  input  logic [IdxW-1:0] rd_addr,
  output entry_t          rd_data
);

  // One write and one registered read per cycle.
  entry_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/peer_table_with_aging_and_election_top.sv]
// Peer table with aging and key server election.
//
// Items arrive on the s_axis channel (operation, peer id, priority, stamp,
// status, index, now and last flag) and each one gives exactly one result item
// on m_axis (result code, found index, counts, batch flag, purge count and
// election outcome). The user must write the configuration registers (timeout,
// own id, own priority) through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this.
// The table lives in a small memory with one write and one registered read
// port. A sequencer walks the entries through that port, and a shared compare
// unit checks id match, age or election order each step. Each entry visited
// takes a read state, then a check or a shifted write. A lookup miss, merge
// miss, election, purge or delete at index 0 visits every stored entry.
// s_axis_tready is high only in the idle state.
//
// Reset (synchronous rst) empties the table by clearing the entry and live
// counts; entries are never read past the count so no clearing pass is run.
// If the receiver stalls, the result stays in the output register and no
// new item is accepted until it has been taken.
module peer_table_with_aging_and_election_top
  import ptae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operation[2:0], peer_id[33:3], priority_req[41:34],
  // time_stamp[53:42], new_status[54], entry_index[58:55], now[70:59], pad
  input  logic [71:0] s_axis_tdata,
  // tlast: last_record
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_code[1:0], found_index[5:2], entry_total[10:6],
  // live_total[15:11], batch_changed[16], removed_count[21:17],
  // winner_priority[29:22], self_is_key_server[30], pad
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [TimeW-1:0] timeout_seconds;
  logic [PeerW-1:0] own_peer_id;
  logic [PrioW-1:0] own_priority;

  logic [2:0]       op;
  logic [PeerW-1:0] req_id;
  logic [PrioW-1:0] req_prio;
  logic [TimeW-1:0] req_ts;
  logic             req_status;
  logic [TimeW-1:0] req_now;
  logic             req_last;

  logic [CntW-1:0]  entry_count;
  logic [CntW-1:0]  live_count;
  logic             batch_added;

  logic [CntW-1:0]  ptr;      // current entry being visited
  logic [CntW-1:0]  dst;      // purge/delete compaction write position
  logic [CntW-1:0]  removed;
  logic             found;
  logic [IdxW-1:0]  found_pos;
  logic [PrioW-1:0] best_prio;
  logic [PeerW-1:0] best_id;
  logic             self_win;
  logic [1:0]       code;
  logic             changed;

  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  entry_t           wr_data;
  logic [IdxW-1:0]  rd_addr;
  entry_t           rd_data;

  ptae_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);

  logic scan_end;
  assign scan_end = (ptr >= entry_count);
  assign rd_addr = ptr[IdxW-1:0];

  // Shared compare unit: one entry against the current operation.
  logic id_hit, stale, better;
  always_comb begin
    id_hit = (rd_data.peer_id == req_id);
    stale  = age_above(req_now, rd_data.seen_time, timeout_seconds);
    better = rd_data.live && ((rd_data.priority_val > best_prio) ||
             ((rd_data.priority_val == best_prio) && (rd_data.peer_id > best_id)));
  end

  logic fresh_req;
  assign fresh_req = age_below(req_now, req_ts, timeout_seconds);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TimeW'(6);
      own_peer_id <= '0;
      own_priority <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_seconds <= cfg_data[TimeW-1:0];
        REG_OWN_ID:   own_peer_id <= cfg_data[PeerW-1:0];
        REG_OWN_PRIO: own_priority <= cfg_data[PrioW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      live_count <= '0;
      batch_added <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op         <= s_axis_tdata[2:0];
            req_id     <= s_axis_tdata[33:3];
            req_prio   <= s_axis_tdata[41:34];
            req_ts     <= s_axis_tdata[53:42];
            req_status <= s_axis_tdata[54];
            req_now    <= s_axis_tdata[70:59];
            req_last   <= s_axis_tlast;
            code <= RC_OK;
            changed <= 1'b0;
            removed <= '0;
            found <= 1'b0;
            found_pos <= '0;
            best_prio <= own_priority;
            best_id <= own_peer_id;
            // The own node wins the election unless a live entry beats it.
            self_win <= 1'b1;
            // Status and delete start at the requested index.
            if (s_axis_tdata[2:0] == OP_STATUS || s_axis_tdata[2:0] == OP_DELETE) begin
              ptr <= CntW'(s_axis_tdata[58:55]);
            end else begin
              ptr <= '0;
            end
            dst <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // Read address is ptr; data appears next cycle.
          case (op)
            OP_MERGE, OP_LOOKUP: state <= (scan_end || found) ? S_DONE : S_CHECK;
            OP_STATUS: begin
              if (scan_end) begin
                code <= RC_BAD_INDEX;
                state <= S_DONE;
              end else begin
                state <= S_CHECK;
              end
            end
            OP_DELETE: begin
              if (scan_end) begin
                code <= RC_BAD_INDEX;
                state <= S_DONE;
              end else begin
                state <= S_CHECK;
              end
            end
            OP_PURGE, OP_ELECT: state <= scan_end ? S_DONE : S_CHECK;
            default: state <= S_DONE;
          endcase
        end
        S_CHECK: begin
          case (op)
            OP_MERGE, OP_LOOKUP: begin
              if (id_hit) begin
                found <= 1'b1;
                found_pos <= ptr[IdxW-1:0];
                if (op == OP_MERGE && fresh_req && rd_data.seen_time < req_ts) begin
                  wr_en <= 1'b1;
                  wr_addr <= ptr[IdxW-1:0];
                  wr_data <= '{peer_id: rd_data.peer_id, priority_val: rd_data.priority_val,
                               seen_time: req_ts, live: rd_data.live};
                end
                state <= S_DONE;
              end else begin
                ptr <= ptr + 1'b1;
                state <= S_READ;
              end
            end
            OP_STATUS: begin
              if (req_status && !rd_data.live) begin
                live_count <= live_count + 1'b1;
              end else if (!req_status && rd_data.live && live_count != '0) begin
                live_count <= live_count - 1'b1;
              end
              wr_en <= 1'b1;
              wr_addr <= ptr[IdxW-1:0];
              wr_data <= '{peer_id: rd_data.peer_id, priority_val: rd_data.priority_val,
                           seen_time: req_now, live: req_status};
              state <= S_DONE;
            end
            OP_DELETE: begin
              if (rd_data.live && live_count != '0) begin
                live_count <= live_count - 1'b1;
              end
              dst <= ptr;
              ptr <= ptr + 1'b1;
              state <= S_SHIFT;
            end
            OP_PURGE: begin
              if (stale) begin
                if (rd_data.live && live_count != '0) begin
                  live_count <= live_count - 1'b1;
                end
                removed <= removed + 1'b1;
              end else begin
                if (dst != ptr) begin
                  wr_en <= 1'b1;
                  wr_addr <= dst[IdxW-1:0];
                  wr_data <= rd_data;
                end
                dst <= dst + 1'b1;
              end
              ptr <= ptr + 1'b1;
              state <= S_READ;
            end
            OP_ELECT: begin
              if (better) begin
                best_prio <= rd_data.priority_val;
                best_id <= rd_data.peer_id;
                self_win <= 1'b0;
              end
              ptr <= ptr + 1'b1;
              state <= S_READ;
            end
            default: state <= S_DONE;
          endcase
        end
        S_SHIFT: begin
          // Delete compaction: wait for the read at ptr.
          state <= scan_end ? S_DONE : S_WRITE;
        end
        S_WRITE: begin
          wr_en <= 1'b1;
          wr_addr <= dst[IdxW-1:0];
          wr_data <= rd_data;
          dst <= dst + 1'b1;
          ptr <= ptr + 1'b1;
          state <= S_SHIFT;
        end
        S_DONE: begin
          case (op)
            OP_MERGE: begin
              if (!found && fresh_req && req_id != own_peer_id) begin
                if (entry_count >= CntW'(TableDepth)) begin
                  code <= RC_FULL;
                  changed <= req_last & batch_added;
                  if (req_last) batch_added <= 1'b0;
                end else begin
                  wr_en <= 1'b1;
                  wr_addr <= entry_count[IdxW-1:0];
                  wr_data <= '{peer_id: req_id, priority_val: req_prio,
                               seen_time: req_ts, live: 1'b1};
                  entry_count <= entry_count + 1'b1;
                  live_count <= live_count + 1'b1;
                  changed <= req_last;
                  batch_added <= !req_last;
                end
              end else begin
                changed <= req_last & batch_added;
                if (req_last) batch_added <= 1'b0;
              end
            end
            OP_DELETE: if (code == RC_OK) entry_count <= entry_count - 1'b1;
            OP_PURGE: entry_count <= dst;
            OP_LOOKUP: if (!found) code <= RC_NOT_FOUND;
            default: ;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[1:0]   = code;
    m_axis_tdata[5:2]   = (op == OP_LOOKUP && found) ? found_pos : '0;
    m_axis_tdata[10:6]  = entry_count;
    m_axis_tdata[15:11] = live_count;
    m_axis_tdata[16]    = (op == OP_MERGE) ? changed : 1'b0;
    m_axis_tdata[21:17] = (op == OP_PURGE) ? removed : '0;
    m_axis_tdata[29:22] = (op == OP_ELECT) ? best_prio : '0;
    m_axis_tdata[30]    = (op == OP_ELECT) ? self_win : 1'b0;
  end

  a_live_le_entries: assert property (@(posedge clk) disable iff (rst)
    live_count <= entry_count) else $error("live count exceeds entry count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(TableDepth)) else $error("entry count overflow");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !m_axis_tready) |=> state == S_OUT)
    else $error("result dropped");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> !wr_en || $past(state) != S_IDLE)
    else $error("table written while idle");

endmodule
